/* hw/rtl/mexp_pkg.sv */
// Shared widths, stream packing and sequencer constants for the modular exponentiation core.
package mexp_pkg;

    localparam int unsigned BASE_W = 31;
    localparam int unsigned EXP_W  = 63;
    localparam int unsigned MOD_W  = 31;
    localparam int unsigned OUT_W  = 31;

    // Stream packing: fields from the lowest bit up, padded to whole bytes.
    localparam int unsigned BASE_LSB = 0;
    localparam int unsigned EXP_LSB  = BASE_LSB + BASE_W;
    localparam int unsigned MOD_LSB  = EXP_LSB + EXP_W;
    localparam int unsigned IN_BITS  = MOD_LSB + MOD_W;
    localparam int unsigned S_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned M_DATA_W = ((OUT_W + 7) / 8) * 8;

    // Width of the doubled partial remainder plus addend, and of its signed differences.
    localparam int unsigned SUM_W  = MOD_W + 2;
    localparam int unsigned DIFF_W = SUM_W + 1;

    // One modular multiply walks all multiplier bits; the counter indexes the last step.
    localparam int unsigned CNT_W    = $clog2(MOD_W);
    localparam int unsigned LAST_CNT = MOD_W - 1;

endpackage

/* hw/rtl/modular_exponentiation_core.sv */
// Top level of the modular exponentiation core: sequencer around one shared modular step unit.
//
// The core computes base ** exponent mod modulus by right-to-left square-and-multiply.
// A request carries a 31-bit base, a 63-bit exponent and a 31-bit modulus;
// the core returns one 31-bit result per request. An exponent of zero returns 1 for every
// modulus, and a zero modulus with a nonzero exponent returns 0. All arithmetic runs through
// a single interleaved shift-add-reduce unit that handles one multiplier bit per cycle, so a
// modular multiplication walks all multiplier bits. The base is first reduced modulo the
// modulus; after that, each exponent bit position costs one pass through the decision state,
// a squaring for every position below the top set bit, and a further decision and a multiply
// into the accumulator for every set bit. The zero-exponent and zero-modulus cases skip the
// arithmetic and go straight to the finish state. The core takes one request at a
// time: s_tready is high only while the sequencer is idle. A finished result sits in an
// output register until taken, and the core may accept and start the next request meanwhile.
module modular_exponentiation_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0 up: base[30:0], exponent[93:31], modulus[124:94], zero pad
    input  logic [mexp_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0 up: power_mod[30:0], zero pad
    output logic [mexp_pkg::M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_REDUCE,
        S_DECIDE,
        S_MULACC,
        S_SQUARE,
        S_FINISH
    } state_t;

    state_t                            state_reg, state_next;
    logic                              out_valid_reg, out_valid_next;
    logic [mexp_pkg::OUT_W-1:0]        out_data_reg, out_data_next;

    logic [mexp_pkg::EXP_W-1:0]        exp_reg, exp_next;
    logic [mexp_pkg::MOD_W-1:0]        mod_reg, mod_next;
    logic [mexp_pkg::MOD_W-1:0]        acc_reg, acc_next;
    logic [mexp_pkg::MOD_W-1:0]        sq_reg, sq_next;
    logic [mexp_pkg::MOD_W-1:0]        a_reg, a_next;
    logic [mexp_pkg::MOD_W-1:0]        b_reg, b_next;
    logic [mexp_pkg::MOD_W-1:0]        r_reg, r_next;
    logic [mexp_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    logic [mexp_pkg::BASE_W-1:0]       in_base;
    logic [mexp_pkg::EXP_W-1:0]        in_exp;
    logic [mexp_pkg::MOD_W-1:0]        in_mod;

    logic [mexp_pkg::SUM_W-1:0]        step_sum;
    logic [mexp_pkg::DIFF_W-1:0]       step_d1;
    logic [mexp_pkg::DIFF_W-1:0]       step_d2;
    logic [mexp_pkg::MOD_W-1:0]        step_out;
    logic                              last_step;
    logic                              out_free;

    assign in_base = s_tdata[mexp_pkg::BASE_LSB +: mexp_pkg::BASE_W];
    assign in_exp  = s_tdata[mexp_pkg::EXP_LSB  +: mexp_pkg::EXP_W];
    assign in_mod  = s_tdata[mexp_pkg::MOD_LSB  +: mexp_pkg::MOD_W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mexp_pkg::M_DATA_W - mexp_pkg::OUT_W){1'b0}}, out_data_reg};

    assign out_free  = !out_valid_reg || m_tready;
    assign last_step = (cnt_reg == mexp_pkg::CNT_W'(mexp_pkg::LAST_CNT));

    // Shared modular step: r <- (2r + (msb of b ? a : 0)) mod m. With r < m and a < m the
    // sum stays below 3m, so at most two subtractions of m bring it back into range; both
    // candidates are formed in parallel and the right one is picked by the borrows.
    always_comb
    begin
        step_sum = {1'b0, r_reg, 1'b0}
                 + (b_reg[mexp_pkg::MOD_W-1] ? {2'b00, a_reg} : {mexp_pkg::SUM_W{1'b0}});
        step_d1  = {1'b0, step_sum} - {3'b000, mod_reg};
        step_d2  = {1'b0, step_sum} - {2'b00, mod_reg, 1'b0};
        if (!step_d2[mexp_pkg::DIFF_W-1])
        begin
            step_out = step_d2[mexp_pkg::MOD_W-1:0];
        end
        else if (!step_d1[mexp_pkg::DIFF_W-1])
        begin
            step_out = step_d1[mexp_pkg::MOD_W-1:0];
        end
        else
        begin
            step_out = step_sum[mexp_pkg::MOD_W-1:0];
        end
    end

    // Sequencer. The base is reduced first by running the step unit with a = 1 over the
    // base bits; the multiply states then always see a multiplicand below the modulus.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        exp_next       = exp_reg;
        mod_next       = mod_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    exp_next = in_exp;
                    mod_next = in_mod;
                    r_next   = '0;
                    cnt_next = '0;
                    if (in_exp == '0)
                    begin
                        acc_next   = mexp_pkg::MOD_W'(1);
                        state_next = S_FINISH;
                    end
                    else if (in_mod == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        acc_next   = mexp_pkg::MOD_W'(1);
                        a_next     = mexp_pkg::MOD_W'(1);
                        b_next     = in_base;
                        state_next = S_REDUCE;
                    end
                end
            end

            S_REDUCE, S_MULACC, S_SQUARE:
            begin
                r_next   = step_out;
                b_next   = {b_reg[mexp_pkg::MOD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = S_DECIDE;
                    if (state_reg == S_MULACC)
                    begin
                        acc_next   = step_out;
                        exp_next[0] = 1'b0;
                    end
                    else
                    begin
                        sq_next = step_out;
                    end
                end
            end

            S_DECIDE:
            begin
                r_next   = '0;
                cnt_next = '0;
                a_next   = sq_reg;
                if (exp_reg[0])
                begin
                    // Set bit: fold the running square into the accumulator.
                    b_next     = acc_reg;
                    state_next = S_MULACC;
                end
                else
                begin
                    exp_next = {1'b0, exp_reg[mexp_pkg::EXP_W-1:1]};
                    b_next   = sq_reg;
                    if (exp_reg[mexp_pkg::EXP_W-1:1] == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SQUARE;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg <= exp_next;
        mod_reg <= mod_next;
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    // The partial remainder must stay reduced for the two-subtraction step to be exact.
    a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REDUCE || state_reg == S_MULACC || state_reg == S_SQUARE)
            |-> (r_reg < mod_reg))
        else $error("partial remainder not below modulus");

    // In the multiply states the multiplicand is an already reduced square.
    a_mcand_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MULACC || state_reg == S_SQUARE) |-> (a_reg < mod_reg))
        else $error("multiplicand not reduced");

    // A result is only loaded when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !m_tready) |=> (state_reg == S_FINISH))
        else $error("pending result overwritten");

    // An accepted request keeps the core busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("core ready right after accepting a request");

endmodule

/* verif/tb_modular_exponentiation_core.sv */
// Self-checking testbench for the modular exponentiation core: directed table, then random requests.
module tb_modular_exponentiation_core;

    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog limit counts only cycles in which neither side moves a
    // request or a result.
    localparam int unsigned STALL_LIMIT = 20000;
    // After the last result, watch a little longer for anything spurious.
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned N_RANDOM = 132;

    localparam logic [mexp_pkg::BASE_W-1:0] BASE_MAX = '1;
    localparam logic [mexp_pkg::EXP_W-1:0]  EXP_MAX  = '1;
    localparam logic [mexp_pkg::MOD_W-1:0]  MOD_MAX  = '1;

    // Idling phases: none, sender idle, receiver stalling, both.
    localparam int unsigned SEND_IDLE_PCT [4] = '{0, 83, 0, 35};
    localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 83, 35};

    // Where the expected power of a directed row comes from.
    typedef enum logic
    {
        BY_PREDICTOR,
        TYPED_IN
    } expect_src_t;

    typedef struct packed
    {
        logic [mexp_pkg::BASE_W-1:0] base;
        logic [mexp_pkg::EXP_W-1:0]  exponent;
        logic [mexp_pkg::MOD_W-1:0]  modulus;
        expect_src_t                 src;
        logic [mexp_pkg::OUT_W-1:0]  power_mod;
    } directed_row_t;

    localparam int unsigned N_DIRECTED = 18;

    // Directed requests. The expected power is typed in only where it is obvious:
    // a zero exponent, modulus one or zero, a zero base or one equal to the modulus, small exact powers.
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{31'd5,          63'd0,          31'd7,          TYPED_IN,     31'd1},
        '{31'd0,          63'd0,          31'd1,          TYPED_IN,     31'd1},
        '{BASE_MAX,       63'd0,          MOD_MAX,        TYPED_IN,     31'd1},
        '{31'd0,          63'd0,          31'd0,          TYPED_IN,     31'd1},
        '{BASE_MAX,       EXP_MAX,        31'd1,          TYPED_IN,     31'd0},
        '{31'd123,        63'd45,         31'd0,          TYPED_IN,     31'd0},
        '{31'd0,          63'd5,          31'd13,         TYPED_IN,     31'd0},
        '{31'd9,          63'd1,          31'd10,         TYPED_IN,     31'd9},
        '{31'd2,          63'd10,         MOD_MAX,        TYPED_IN,     31'd1024},
        '{31'd1,          EXP_MAX,        31'd7,          TYPED_IN,     31'd1},
        '{BASE_MAX,       EXP_MAX,        MOD_MAX,        TYPED_IN,     31'd0},
        '{BASE_MAX,       63'd1,          31'd1000,       BY_PREDICTOR, 31'd0},
        '{BASE_MAX,       EXP_MAX,        MOD_MAX - 31'd1, BY_PREDICTOR, 31'd0},
        '{BASE_MAX - 31'd1, EXP_MAX,      MOD_MAX,        BY_PREDICTOR, 31'd0},
        '{31'd2,          63'd1 << 62,    31'd1000003,    BY_PREDICTOR, 31'd0},
        '{31'd65536,      63'd2,          MOD_MAX,        BY_PREDICTOR, 31'd0},
        '{31'h2AAA_AAAA,  63'h2AAA_AAAA_AAAA_AAAA, 31'h5555_5555, BY_PREDICTOR, 31'd0},
        '{31'h5555_5555,  63'h5555_5555_5555_5555, 31'h2AAA_AAAB, BY_PREDICTOR, 31'd0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mexp_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mexp_pkg::M_DATA_W-1:0] m_tdata;

    // Expected power of the request currently offered on the slave side; it is
    // queued at the edge where the core takes the request.
    logic [mexp_pkg::OUT_W-1:0]    offered_power_mod = '0;
    logic [mexp_pkg::OUT_W-1:0]    pending_power_mod [$];

    int unsigned         send_idle_pct = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         mismatches = 0;

    modular_exponentiation_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Right-to-left square-and-multiply. Operands stay below 2^31, so every
    // product fits in 64 bits before it is reduced.
    function automatic logic [mexp_pkg::OUT_W-1:0] power_mod_of(
        input logic [mexp_pkg::BASE_W-1:0] base,
        input logic [mexp_pkg::EXP_W-1:0]  exponent,
        input logic [mexp_pkg::MOD_W-1:0]  modulus);
        logic [63:0]                acc;
        logic [63:0]                square;
        logic [mexp_pkg::EXP_W-1:0] rest;
        if (exponent == '0)
            return mexp_pkg::OUT_W'(1);
        // A zero modulus cannot reduce anything; the core answers zero.
        if (modulus == '0)
            return '0;
        acc = 64'd1;
        square = 64'(base);
        rest = exponent;
        while (rest != '0)
        begin
            if (rest[0])
                acc = (acc * square) % 64'(modulus);
            rest = rest >> 1;
            if (rest != '0)
                square = (square * square) % 64'(modulus);
        end
        return acc[mexp_pkg::OUT_W-1:0];
    endfunction

    // Offers one request, starting and ending at a falling edge. Idle cycles are
    // inserted before the request as the current phase asks; once raised, the
    // valid stays high until the core takes the request.
    task automatic send_request(input logic [mexp_pkg::BASE_W-1:0] base,
                                input logic [mexp_pkg::EXP_W-1:0]  exponent,
                                input logic [mexp_pkg::MOD_W-1:0]  modulus,
                                input logic [mexp_pkg::OUT_W-1:0]  power_mod);
        logic [mexp_pkg::S_DATA_W-1:0] word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        word = '0;
        word[mexp_pkg::BASE_LSB +: mexp_pkg::BASE_W] = base;
        word[mexp_pkg::EXP_LSB +: mexp_pkg::EXP_W] = exponent;
        word[mexp_pkg::MOD_LSB +: mexp_pkg::MOD_W] = modulus;
        s_tdata <= word;
        offered_power_mod <= power_mod;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The receiver decides at each falling edge whether to stall the next cycle.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Scoreboard: queue the expected power when a request is taken, and compare
    // every result taken from the core with the oldest expectation.
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            pending_power_mod.push_back(offered_power_mod);
        if (m_tvalid && m_tready)
        begin
            if (pending_power_mod.size() == 0)
            begin
                $error("power_mod: expected no result, actual %0d",
                       m_tdata[mexp_pkg::OUT_W-1:0]);
                mismatches <= mismatches + 1;
            end
            else if (m_tdata[mexp_pkg::OUT_W-1:0] !== pending_power_mod[0])
            begin
                $error("power_mod: expected %0d, actual %0d",
                       pending_power_mod[0], m_tdata[mexp_pkg::OUT_W-1:0]);
                mismatches <= mismatches + 1;
                void'(pending_power_mod.pop_front());
            end
            else
            begin
                void'(pending_power_mod.pop_front());
            end
        end
    end

    // Watchdog: a hung core or a lost result stops the run here.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("modular_exponentiation_core: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        directed_row_t                 row;
        logic [mexp_pkg::BASE_W-1:0]   base;
        logic [mexp_pkg::EXP_W-1:0]    exponent;
        logic [mexp_pkg::MOD_W-1:0]    modulus;
        logic [mexp_pkg::OUT_W-1:0]    want;
        int unsigned                   phase;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part runs without idling on either side.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.src == TYPED_IN)
                want = row.power_mod;
            else
                want = power_mod_of(row.base, row.exponent, row.modulus);
            send_request(row.base, row.exponent, row.modulus, want);
        end

        // Let the core and the result queue drain completely before going on.
        s_tvalid <= 1'b0;
        while (pending_power_mod.size() != 0)
            @(negedge clk);

        // Random requests in four idling phases. Most exponents are short so the
        // run stays brief; one in eight spans all 63 bits.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            phase = (i * 4) / N_RANDOM;
            send_idle_pct = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];

            base = mexp_pkg::BASE_W'($urandom);
            if ($urandom_range(7) == 0)
                base = mexp_pkg::BASE_W'($urandom_range(3));

            exponent = mexp_pkg::EXP_W'({$urandom, $urandom});
            if ($urandom_range(7) != 0)
                exponent = exponent & ~(EXP_MAX << $urandom_range(20));

            case ($urandom_range(15))
                0:       modulus = mexp_pkg::MOD_W'($urandom_range(2));
                1, 2:    modulus = mexp_pkg::MOD_W'($urandom_range(16, 1));
                default: modulus = mexp_pkg::MOD_W'($urandom);
            endcase

            send_request(base, exponent, modulus, power_mod_of(base, exponent, modulus));
        end

        s_tvalid <= 1'b0;
        while (pending_power_mod.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("modular_exponentiation_core: match");
        else
            $display("modular_exponentiation_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mexp_pkg.sv
hw/rtl/modular_exponentiation_core.sv
verif/tb_modular_exponentiation_core.sv
